### rtl/pidsl_pkg.sv
// Shared types, widths and register codes of the slew-limited PID controller.
package pidsl_pkg;

    localparam int MEAS_W  = 16;
    localparam int GAIN_W  = 40;
    localparam int ERR_W   = 17;
    localparam int DTERM_W = 18;
    localparam int SUM_W   = 48;
    localparam int RAW_W   = 42;
    localparam int TRACK_W = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 40;

    localparam logic [MEAS_W-1:0] SETPOINT_RST  = 16'd0;
    localparam logic [GAIN_W-1:0] KP_RST        = 40'd4362076160;
    localparam logic [GAIN_W-1:0] KI_RST        = 40'd5033;
    localparam logic [GAIN_W-1:0] KD_RST        = 40'd168;
    localparam logic [MEAS_W-1:0] MAX_OUT_RST   = 16'd65535;
    localparam logic [MEAS_W-1:0] SLEW_THR_RST  = 16'd2000;
    localparam logic [MEAS_W-1:0] SLEW_STEP_RST = 16'd10;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SETPOINT  = 3'd0,
        REG_KP        = 3'd1,
        REG_KI        = 3'd2,
        REG_KD        = 3'd3,
        REG_MAX_OUT   = 3'd4,
        REG_SLEW_THR  = 3'd5,
        REG_SLEW_STEP = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic [GAIN_W-1:0] kp;
        logic [GAIN_W-1:0] ki;
        logic [GAIN_W-1:0] kd;
    } gains_t;

    typedef struct packed {
        logic [MEAS_W-1:0] drive_max;
        logic [MEAS_W-1:0] slew_threshold;
        logic [MEAS_W-1:0] slew_step;
    } limits_t;

    typedef struct packed {
        logic [ERR_W-1:0]   err;
        logic [SUM_W-1:0]   err_sum;
        logic [DTERM_W-1:0] dterm;
    } front_t;

    typedef struct packed {
        logic [RAW_W-1:0] raw_on;
        logic [RAW_W-1:0] raw_off;
    } raw_pair_t;

    typedef struct packed {
        logic               integral_on;
        logic [TRACK_W-1:0] tracked;
    } out_stat_t;

endpackage

### rtl/pid_controller_slew_limited.sv
// Top level of the positional PID controller with slew tracking and integral gating.
//
//  channel | beat moves on       | payload
//  --------+---------------------+-----------------------------------------
//  in      | in_valid & in_ready | measurement[15:0]
//  out     | out_valid&out_ready | drive[15:0], slew_limited, clamped_high
//  cfg     | cfg_valid&cfg_ready | cfg_index[2:0], cfg_data[39:0]
//
//  One measurement beat per cycle sustained while the result side is ready; a result
//  beat passes the history stage, five product stages and the result register.
//  The depth is set by the 40-bit gain products, split into 20-bit gain halves.
//  Ready ripples back through empty stages in the same cycle; bubbles squeeze out.
//  Reset clears error history, sum, tracker and integral gate, and loads
//  default gains and limits; there is no clearing pass.
module pid_controller_slew_limited (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [pidsl_pkg::MEAS_W-1:0]         measurement,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [pidsl_pkg::MEAS_W-1:0]         drive,
    output logic                                 slew_limited,
    output logic                                 clamped_high,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [pidsl_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pidsl_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import pidsl_pkg::*;

    // Configuration registers; always ready, written one beat at a time.
    logic [MEAS_W-1:0] setpoint_reg, setpoint_next;
    gains_t            gains_reg, gains_next;
    limits_t           limits_reg, limits_next;
    logic              cfg_we;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    always_comb
    begin
        setpoint_next = setpoint_reg;
        gains_next    = gains_reg;
        limits_next   = limits_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SETPOINT:  setpoint_next              = cfg_data[MEAS_W-1:0];
                REG_KP:        gains_next.kp              = cfg_data[GAIN_W-1:0];
                REG_KI:        gains_next.ki              = cfg_data[GAIN_W-1:0];
                REG_KD:        gains_next.kd              = cfg_data[GAIN_W-1:0];
                REG_MAX_OUT:   limits_next.drive_max      = cfg_data[MEAS_W-1:0];
                REG_SLEW_THR:  limits_next.slew_threshold = cfg_data[MEAS_W-1:0];
                REG_SLEW_STEP: limits_next.slew_step      = cfg_data[MEAS_W-1:0];
                default:       setpoint_next              = setpoint_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            setpoint_reg              <= SETPOINT_RST;
            gains_reg.kp              <= KP_RST;
            gains_reg.ki              <= KI_RST;
            gains_reg.kd              <= KD_RST;
            limits_reg.drive_max      <= MAX_OUT_RST;
            limits_reg.slew_threshold <= SLEW_THR_RST;
            limits_reg.slew_step      <= SLEW_STEP_RST;
        end
        else
        begin
            setpoint_reg <= setpoint_next;
            gains_reg    <= gains_next;
            limits_reg   <= limits_next;
        end
    end

    // Error, sum and derivative: history state advances on each input beat.
    logic      front_valid, front_ready;
    front_t    front_data;

    pidsl_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .measurement (measurement),
        .setpoint    (setpoint_reg),
        .out_valid   (front_valid),
        .out_ready   (front_ready),
        .out_data    (front_data)
    );

    // Products and raw outputs, computed both with and without the integral
    // term so the gate decision can wait for the previous result.
    logic      raw_valid, raw_ready;
    raw_pair_t raw_data;

    pidsl_mult u_mult (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_data   (front_data),
        .gains     (gains_reg),
        .out_valid (raw_valid),
        .out_ready (raw_ready),
        .out_data  (raw_data)
    );

    // Gate select, tracker, clamp; holds the result until the beat is taken.
    out_stat_t stat;

    pidsl_out u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (raw_valid),
        .in_ready     (raw_ready),
        .in_data      (raw_data),
        .limits       (limits_reg),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .drive        (drive),
        .slew_limited (slew_limited),
        .clamped_high (clamped_high),
        .stat         (stat)
    );

`ifndef ASSERT_OFF
    // An empty result register frees every stage back to the input.
    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty result register");

    // The integral gate for the next beat follows the high clamp of this one.
    a_gate_tracks_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (clamped_high != stat.integral_on))
        else $error("integral gate disagrees with high clamp");

    // A tracked result within range is shown as the tracker value itself.
    a_slew_shows_tracker: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && slew_limited && !clamped_high && !stat.tracked[TRACK_W-1])
        |-> (drive == stat.tracked[MEAS_W-1:0]))
        else $error("slew-limited drive differs from tracker");
`endif

endmodule

### rtl/pidsl_front.sv
// Error, saturating error sum and derivative history; first pipeline stage.
module pidsl_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [pidsl_pkg::MEAS_W-1:0]      measurement,
    input  logic [pidsl_pkg::MEAS_W-1:0]      setpoint,
    output logic                              out_valid,
    input  logic                              out_ready,
    output pidsl_pkg::front_t                 out_data
);
    import pidsl_pkg::*;

    logic signed [ERR_W-1:0]   last_err_reg, last_err_next;
    logic signed [ERR_W-1:0]   prev_err_reg, prev_err_next;
    logic signed [SUM_W-1:0]   err_sum_reg, err_sum_next;
    logic                      vld_reg, vld_next;
    front_t                    data_reg, data_next;

    logic signed [ERR_W-1:0]   err;
    logic signed [SUM_W:0]     sum_wide;
    logic signed [SUM_W-1:0]   sum_sat;
    logic signed [DTERM_W-1:0] dterm;
    logic                      accept;

    assign in_ready = !vld_reg || out_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        err      = $signed({1'b0, setpoint}) - $signed({1'b0, measurement});
        sum_wide = {err_sum_reg[SUM_W-1], err_sum_reg}
                 + {{(SUM_W-ERR_W+1){err[ERR_W-1]}}, err};
        // saturate at the 48-bit signed limits
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1])
        begin
            sum_sat = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                      : {1'b0, {(SUM_W-1){1'b1}}};
        end
        else
        begin
            sum_sat = sum_wide[SUM_W-1:0];
        end
        dterm = {last_err_reg[ERR_W-1], last_err_reg}
              - {prev_err_reg[ERR_W-1], prev_err_reg};

        last_err_next = accept ? err : last_err_reg;
        prev_err_next = accept ? last_err_reg : prev_err_reg;
        err_sum_next  = accept ? sum_sat : err_sum_reg;

        vld_next          = in_ready ? in_valid : vld_reg;
        data_next         = data_reg;
        if (accept)
        begin
            data_next.err     = err;
            data_next.err_sum = sum_sat;
            data_next.dterm   = dterm;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_err_reg <= '0;
            prev_err_reg <= '0;
            err_sum_reg  <= '0;
            vld_reg      <= 1'b0;
        end
        else
        begin
            last_err_reg <= last_err_next;
            prev_err_reg <= prev_err_next;
            err_sum_reg  <= err_sum_next;
            vld_reg      <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = vld_reg;
    assign out_data  = data_reg;

endmodule

### rtl/pidsl_mult.sv
// Gain products over split partial products, term sums and truncated raw outputs.
module pidsl_mult (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  pidsl_pkg::front_t    in_data,
    input  pidsl_pkg::gains_t    gains,
    output logic                 out_valid,
    input  logic                 out_ready,
    output pidsl_pkg::raw_pair_t out_data
);
    import pidsl_pkg::*;

    localparam int STAGES = 5;
    localparam int TOT_W  = 90;
    localparam int FL_W   = TOT_W - 24;
    localparam logic signed [FL_W-1:0] RAW_MAX = 66'sh100_0000_0000;
    localparam logic signed [FL_W-1:0] RAW_MIN = -RAW_MAX;

    // truncate a Q.24 total toward zero and saturate to +-2^40
    function automatic logic [RAW_W-1:0] to_raw(input logic signed [TOT_W-1:0] t);
        logic signed [FL_W-1:0] fl;
        logic signed [FL_W-1:0] q;
        logic                   adj;
        fl  = t[TOT_W-1:24];
        adj = t[TOT_W-1] && (|t[23:0]);
        q   = fl + $signed({{(FL_W-1){1'b0}}, adj});
        if (q > RAW_MAX)
        begin
            q = RAW_MAX;
        end
        else if (q < RAW_MIN)
        begin
            q = RAW_MIN;
        end
        return q[RAW_W-1:0];
    endfunction

    logic [STAGES-1:0] vld_reg, vld_next;
    logic [STAGES-1:0] rdy;

    // stage 1: partial products
    logic signed [37:0] kp_lo_p_reg, kp_hi_p_reg, kp_lo_p_next, kp_hi_p_next;
    logic signed [38:0] kd_lo_p_reg, kd_hi_p_reg, kd_lo_p_next, kd_hi_p_next;
    logic signed [45:0] ki_ll_reg, ki_hl_reg, ki_ll_next, ki_hl_next;
    logic signed [44:0] ki_lh_reg, ki_hh_reg, ki_lh_next, ki_hh_next;
    // stage 2: per-gain products, integral product in two halves
    logic signed [57:0] kp_prod_reg, kp_prod_next;
    logic signed [58:0] kd_prod_reg, kd_prod_next;
    logic signed [65:0] ki_x_reg, ki_x_next;
    logic signed [64:0] ki_y_reg, ki_y_next;
    // stage 3
    logic signed [88:0] ki_prod_reg, ki_prod_next;
    logic signed [59:0] pd_reg, pd_next;
    // stage 4
    logic signed [TOT_W-1:0] tot_on_reg, tot_on_next;
    logic signed [59:0]      tot_off_reg, tot_off_next;
    // stage 5
    raw_pair_t raw_reg, raw_next;

    always_comb
    begin
        rdy[STAGES-1] = !vld_reg[STAGES-1] || out_ready;
        for (int i = STAGES - 2; i >= 0; i--)
        begin
            rdy[i] = !vld_reg[i] || rdy[i+1];
        end
        vld_next[0] = rdy[0] ? in_valid : vld_reg[0];
        for (int i = 1; i < STAGES; i++)
        begin
            vld_next[i] = rdy[i] ? vld_reg[i-1] : vld_reg[i];
        end
    end

    assign in_ready = rdy[0];

    always_comb
    begin
        kp_lo_p_next = $signed({1'b0, gains.kp[19:0]}) * $signed(in_data.err);
        kp_hi_p_next = $signed({1'b0, gains.kp[39:20]}) * $signed(in_data.err);
        kd_lo_p_next = $signed({1'b0, gains.kd[19:0]}) * $signed(in_data.dterm);
        kd_hi_p_next = $signed({1'b0, gains.kd[39:20]}) * $signed(in_data.dterm);
        ki_ll_next   = $signed({1'b0, gains.ki[19:0]})
                     * $signed({1'b0, in_data.err_sum[23:0]});
        ki_hl_next   = $signed({1'b0, gains.ki[39:20]})
                     * $signed({1'b0, in_data.err_sum[23:0]});
        ki_lh_next   = $signed({1'b0, gains.ki[19:0]}) * $signed(in_data.err_sum[47:24]);
        ki_hh_next   = $signed({1'b0, gains.ki[39:20]}) * $signed(in_data.err_sum[47:24]);

        kp_prod_next = {{20{kp_lo_p_reg[37]}}, kp_lo_p_reg} + {kp_hi_p_reg, 20'd0};
        kd_prod_next = {{20{kd_lo_p_reg[38]}}, kd_lo_p_reg} + {kd_hi_p_reg, 20'd0};
        ki_x_next    = {{20{ki_ll_reg[45]}}, ki_ll_reg} + {ki_hl_reg, 20'd0};
        ki_y_next    = {{20{ki_lh_reg[44]}}, ki_lh_reg} + {ki_hh_reg, 20'd0};

        ki_prod_next = {{23{ki_x_reg[65]}}, ki_x_reg} + {ki_y_reg, 24'd0};
        pd_next      = {{2{kp_prod_reg[57]}}, kp_prod_reg}
                     + {kd_prod_reg[58], kd_prod_reg};

        tot_on_next  = {{30{pd_reg[59]}}, pd_reg} + {ki_prod_reg[88], ki_prod_reg};
        tot_off_next = pd_reg;

        raw_next.raw_on  = to_raw(tot_on_reg);
        raw_next.raw_off = to_raw({{(TOT_W-60){tot_off_reg[59]}}, tot_off_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // payload advances whenever its stage may take a beat
    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            kp_lo_p_reg <= kp_lo_p_next;
            kp_hi_p_reg <= kp_hi_p_next;
            kd_lo_p_reg <= kd_lo_p_next;
            kd_hi_p_reg <= kd_hi_p_next;
            ki_ll_reg   <= ki_ll_next;
            ki_hl_reg   <= ki_hl_next;
            ki_lh_reg   <= ki_lh_next;
            ki_hh_reg   <= ki_hh_next;
        end
        if (rdy[1])
        begin
            kp_prod_reg <= kp_prod_next;
            kd_prod_reg <= kd_prod_next;
            ki_x_reg    <= ki_x_next;
            ki_y_reg    <= ki_y_next;
        end
        if (rdy[2])
        begin
            ki_prod_reg <= ki_prod_next;
            pd_reg      <= pd_next;
        end
        if (rdy[3])
        begin
            tot_on_reg  <= tot_on_next;
            tot_off_reg <= tot_off_next;
        end
        if (rdy[4])
        begin
            raw_reg <= raw_next;
        end
    end

    assign out_valid = vld_reg[STAGES-1];
    assign out_data  = raw_reg;

endmodule

### rtl/pidsl_out.sv
// Integral gate select, slew tracker, output clamp and result register.
module pidsl_out (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  pidsl_pkg::raw_pair_t          in_data,
    input  pidsl_pkg::limits_t            limits,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [pidsl_pkg::MEAS_W-1:0]  drive,
    output logic                          slew_limited,
    output logic                          clamped_high,
    output pidsl_pkg::out_stat_t          stat
);
    import pidsl_pkg::*;

    logic signed [TRACK_W-1:0] tracked_reg, tracked_next;
    logic                      integral_on_reg, integral_on_next;
    logic                      vld_reg, vld_next;
    logic [MEAS_W-1:0]         drive_reg, drive_next;
    logic                      slew_reg, slew_next;
    logic                      high_reg, high_next;

    logic signed [RAW_W-1:0]   raw;
    logic signed [RAW_W:0]     d_up;
    logic signed [RAW_W:0]     d_dn;
    logic signed [RAW_W:0]     thr;
    logic                      up;
    logic                      slew;
    logic signed [TRACK_W-1:0] tr_step;
    logic signed [RAW_W-1:0]   val;
    logic                      neg;
    logic                      high;
    logic                      accept;

    assign in_ready = !vld_reg || out_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        raw  = integral_on_reg ? in_data.raw_on : in_data.raw_off;
        d_up = {raw[RAW_W-1], raw} - {{(RAW_W-TRACK_W+1){tracked_reg[TRACK_W-1]}}, tracked_reg};
        d_dn = {{(RAW_W-TRACK_W+1){tracked_reg[TRACK_W-1]}}, tracked_reg} - {raw[RAW_W-1], raw};
        thr  = $signed({{(RAW_W-MEAS_W+1){1'b0}}, limits.slew_threshold});
        // equal values count toward a downward step
        up   = d_up > 0;
        slew = up ? (d_up >= thr) : (d_dn >= thr);
        tr_step = up ? tracked_reg + {{(TRACK_W-MEAS_W){1'b0}}, limits.slew_step}
                     : tracked_reg - {{(TRACK_W-MEAS_W){1'b0}}, limits.slew_step};

        val  = slew ? {{(RAW_W-TRACK_W){tr_step[TRACK_W-1]}}, tr_step} : raw;
        neg  = val[RAW_W-1];
        high = neg ? (limits.drive_max == '0)
                   : (val[RAW_W-2:0] >= {{(RAW_W-1-MEAS_W){1'b0}}, limits.drive_max});

        tracked_next     = (accept && slew) ? tr_step : tracked_reg;
        integral_on_next = accept ? !high : integral_on_reg;

        vld_next   = accept ? 1'b1 : (out_ready ? 1'b0 : vld_reg);
        drive_next = drive_reg;
        slew_next  = slew_reg;
        high_next  = high_reg;
        if (accept)
        begin
            if (high)
            begin
                drive_next = limits.drive_max;
            end
            else if (neg)
            begin
                drive_next = '0;
            end
            else
            begin
                drive_next = val[MEAS_W-1:0];
            end
            slew_next = slew;
            high_next = high;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tracked_reg     <= '0;
            integral_on_reg <= 1'b0;
            vld_reg         <= 1'b0;
        end
        else
        begin
            tracked_reg     <= tracked_next;
            integral_on_reg <= integral_on_next;
            vld_reg         <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        drive_reg <= drive_next;
        slew_reg  <= slew_next;
        high_reg  <= high_next;
    end

    assign out_valid        = vld_reg;
    assign drive            = drive_reg;
    assign slew_limited     = slew_reg;
    assign clamped_high     = high_reg;
    assign stat.integral_on = integral_on_reg;
    assign stat.tracked     = tracked_reg;

endmodule

### bench/testbench.sv
// Self-checking testbench for the slew-limited positional PID controller.
module testbench;
    import pidsl_pkg::*;

    // Results pass the history, product and result stages; settle pads a little on top.
    localparam int LATENCY     = 7;
    localparam int CYCLE_LIMIT = 1_000_000;

    localparam logic [GAIN_W-1:0] GAIN_ONE  = 40'h00_0100_0000;  // 1.0 in Q16.24
    localparam logic [GAIN_W-1:0] GAIN_HALF = 40'h00_0080_0000;
    localparam logic [GAIN_W-1:0] GAIN_1P5  = 40'h00_00C0_0000;
    localparam logic [GAIN_W-1:0] GAIN_MAX  = '1;

    localparam logic signed [SUM_W:0] SUM_HI  = {2'b00, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W:0] SUM_LO  = {2'b11, {(SUM_W-1){1'b0}}};
    localparam logic signed [95:0]    RAW_LIM = {55'd0, 1'b1, 40'd0};

    typedef struct packed {
        logic [MEAS_W-1:0] drive;
        logic              slew;
        logic              high;
    } drive_beat_t;

    // ------------------------------------------------------------------
    // Clock, reset and block ports. Every input starts at a known value.
    // ------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [MEAS_W-1:0]     measurement = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [MEAS_W-1:0]     drive;
    logic                  slew_limited;
    logic                  clamped_high;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    cfg_reg_t              cfg_index = REG_SETPOINT;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    pid_controller_slew_limited i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .measurement  (measurement),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .drive        (drive),
        .slew_limited (slew_limited),
        .clamped_high (clamped_high),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // ------------------------------------------------------------------
    // Controller mirror: register copies and loop state, at block widths.
    // ------------------------------------------------------------------
    logic [MEAS_W-1:0] cfg_sp   = SETPOINT_RST;
    logic [GAIN_W-1:0] cfg_kp   = KP_RST;
    logic [GAIN_W-1:0] cfg_ki   = KI_RST;
    logic [GAIN_W-1:0] cfg_kd   = KD_RST;
    logic [MEAS_W-1:0] cfg_max  = MAX_OUT_RST;
    logic [MEAS_W-1:0] cfg_thr  = SLEW_THR_RST;
    logic [MEAS_W-1:0] cfg_step = SLEW_STEP_RST;

    logic signed [ERR_W-1:0]   err_last  = '0;
    logic signed [ERR_W-1:0]   err_prior = '0;
    logic signed [SUM_W-1:0]   err_acc   = '0;
    logic signed [TRACK_W-1:0] track_val = '0;
    logic                      integ_on  = 1'b0;
    logic [MEAS_W-1:0]         last_drive = '0;

    drive_beat_t pending_drive[$];

    int in_gap_max  = 19;
    int out_gap_max = 19;
    int rx_wait     = 0;
    int hold_left   = 0;
    int fail_cnt    = 0;
    int cycle_cnt   = 0;

    // Advance the loop by one measurement and return the drive beat it yields.
    function automatic drive_beat_t predict_drive(input logic [MEAS_W-1:0] meas);
        logic signed [ERR_W-1:0]   err;
        logic signed [DTERM_W-1:0] dlt;
        logic signed [SUM_W:0]     acc_n;
        logic [GAIN_W-1:0]         gki;
        logic signed [95:0]        tot, mag, q, raw, trk_w, thr_w;
        drive_beat_t               res;
        res = '0;
        err = $signed({1'b0, cfg_sp}) - $signed({1'b0, meas});
        acc_n = err_acc + err;
        if (acc_n > SUM_HI)
            err_acc = SUM_HI[SUM_W-1:0];
        else if (acc_n < SUM_LO)
            err_acc = SUM_LO[SUM_W-1:0];
        else
            err_acc = acc_n[SUM_W-1:0];
        dlt = err_last - err_prior;
        err_prior = err_last;
        err_last = err;

        gki = integ_on ? cfg_ki : '0;
        tot = $signed({56'd0, cfg_kp}) * err + $signed({56'd0, gki}) * err_acc
            + $signed({56'd0, cfg_kd}) * dlt;
        // Drop the 24 fraction bits toward zero, then bound the magnitude.
        mag = (tot < 0) ? -tot : tot;
        q = mag >>> 24;
        if (q > RAW_LIM)
            q = RAW_LIM;
        raw = (tot < 0) ? -q : q;

        trk_w = track_val;
        thr_w = $signed({80'd0, cfg_thr});
        if (raw > trk_w)
        begin
            if (raw - trk_w >= thr_w)
            begin
                track_val = track_val + $signed({16'd0, cfg_step});
                raw = track_val;
                res.slew = 1'b1;
            end
        end
        else if (trk_w - raw >= thr_w)
        begin
            track_val = track_val - $signed({16'd0, cfg_step});
            raw = track_val;
            res.slew = 1'b1;
        end

        if (raw < 0)
            raw = '0;
        if (raw >= $signed({80'd0, cfg_max}))
        begin
            raw = {80'd0, cfg_max};
            res.high = 1'b1;
            integ_on = 1'b0;
        end
        else
            integ_on = 1'b1;
        res.drive = raw[MEAS_W-1:0];
        last_drive = res.drive;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Result side. The receiver idles a drawn number of cycles after each
    // beat; a long hold-off, when requested, is counted down here too.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_ready = 1'b0;
            hold_left--;
        end
        else if (rx_wait > 0)
        begin
            out_ready = 1'b0;
            rx_wait--;
        end
        else
            out_ready = 1'b1;
    end

    // Check every drive beat against the oldest prediction.
    always @(posedge clk)
    begin
        drive_beat_t want;
        if (rst_n && out_valid && out_ready)
        begin
            rx_wait = $urandom_range(0, out_gap_max);
            if (pending_drive.size() == 0)
            begin
                $error("drive beat with no measurement pending: drive=%0d", drive);
                fail_cnt++;
            end
            else
            begin
                want = pending_drive.pop_front();
                if (drive !== want.drive)
                begin
                    $error("drive: expected %0d, got %0d", want.drive, drive);
                    fail_cnt++;
                end
                if (slew_limited !== want.slew)
                begin
                    $error("slew_limited: expected %0b, got %0b", want.slew, slew_limited);
                    fail_cnt++;
                end
                if (clamped_high !== want.high)
                begin
                    $error("clamped_high: expected %0b, got %0b", want.high, clamped_high);
                    fail_cnt++;
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Shared drivers
    // ------------------------------------------------------------------

    // Offer one measurement beat after a drawn gap; hold it until taken.
    task automatic send_meas(input logic [MEAS_W-1:0] m);
        int gap;
        gap = $urandom_range(0, in_gap_max);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        measurement = m;
        do
            @(posedge clk);
        while (!in_ready);
        pending_drive.push_back(predict_drive(m));
    endtask

    // Drop valid, let every outstanding drive beat arrive, then let the pipe go quiet.
    task automatic settle();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_drive.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    // Write one register while the block is idle, and mirror it.
    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
        settle();
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_SETPOINT:  cfg_sp   = val[MEAS_W-1:0];
            REG_KP:        cfg_kp   = val[GAIN_W-1:0];
            REG_KI:        cfg_ki   = val[GAIN_W-1:0];
            REG_KD:        cfg_kd   = val[GAIN_W-1:0];
            REG_MAX_OUT:   cfg_max  = val[MEAS_W-1:0];
            REG_SLEW_THR:  cfg_thr  = val[MEAS_W-1:0];
            REG_SLEW_STEP: cfg_step = val[MEAS_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic write_all(input logic [CFG_DATA_W-1:0] sp, kp, ki, kd, mx, thr, st);
        write_reg(REG_SETPOINT, sp);
        write_reg(REG_KP, kp);
        write_reg(REG_KI, ki);
        write_reg(REG_KD, kd);
        write_reg(REG_MAX_OUT, mx);
        write_reg(REG_SLEW_THR, thr);
        write_reg(REG_SLEW_STEP, st);
    endtask

    // With setpoint 32768 and unity kp alone, this measurement makes raw equal target.
    function automatic logic [MEAS_W-1:0] meas_for(input int target);
        return MEAS_W'(32768 - target);
    endfunction

    function automatic logic [GAIN_W-1:0] rand_gain();
        logic [GAIN_W-1:0] g;
        case ($urandom_range(0, 6))
            0: g = '0;
            1: g = '1;
            2: g = {8'($urandom), 32'($urandom)};
            3: g = {16'($urandom_range(0, 300)), 24'($urandom)};
            4: g = {16'($urandom_range(0, 3)), 24'($urandom)};
            5: g = GAIN_W'($urandom_range(0, 20000));
            default: g = {16'($urandom_range(0, 1)), 24'($urandom_range(0, 4000))};
        endcase
        return g;
    endfunction

    // Upper data bits are junk on purpose: the 16-bit registers keep the low 16 bits.
    function automatic logic [CFG_DATA_W-1:0] rand_reg16();
        logic [MEAS_W-1:0] v;
        case ($urandom_range(0, 4))
            0: v = '0;
            1: v = '1;
            2: v = MEAS_W'($urandom_range(0, 3000));
            default: v = MEAS_W'($urandom);
        endcase
        return {24'($urandom), v};
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Run a few beats on the reset gains and limits; integral starts gated off.
    task automatic test_reset_values();
        send_meas(16'd0);
        send_meas(16'hFFFF);
        send_meas(16'd1);
        send_meas(16'h8000);
    endtask

    // Hit the slew threshold one below and exactly, both ways, then zero threshold
    // where raw equal to the tracker counts as a downward step.
    task automatic test_slew_edges();
        write_all(40'd32768, GAIN_ONE, '0, '0, 40'hFFFF, 40'd100, 40'd7);
        send_meas(meas_for(track_val + 99));
        send_meas(meas_for(track_val + 100));
        send_meas(meas_for(track_val - 99));
        send_meas(meas_for(track_val - 100));
        write_reg(REG_SLEW_THR, '0);
        send_meas(meas_for(track_val));
        send_meas(meas_for(track_val + 1));
    endtask

    // Fractional products must truncate toward zero on both signs.
    task automatic test_truncation();
        write_all(40'd1, GAIN_HALF, '0, '0, 40'hFFFF, 40'hFFFF, '0);
        send_meas(16'd0);
        send_meas(16'd2);
        write_reg(REG_KP, GAIN_1P5);
        send_meas(16'd0);
        send_meas(16'd4);
    endtask

    // Near all-ones registers (slew threshold zero), then zero gains and a zero upper clamp.
    task automatic test_register_extremes();
        write_all(40'hFFFF, GAIN_MAX, GAIN_MAX, GAIN_MAX, 40'hFFFF, '0, 40'hFFFF);
        send_meas(16'd0);
        send_meas(16'hFFFF);
        send_meas(16'h5555);
        send_meas(16'hAAAA);
        write_all('0, '0, '0, '0, '0, 40'hFFFF, '0);
        send_meas(16'd0);
        send_meas(16'hFFFF);
    endtask

    // Stall the result side for a long stretch while beats keep coming, so the
    // pipe fills and in_ready must drop.
    task automatic test_backpressure();
        write_all(40'd30000, 2 * GAIN_ONE, 40'd5033, 40'd168, 40'd60000, 40'd500, 40'd50);
        in_gap_max = 0;
        hold_left = 300;
        repeat (40) send_meas(MEAS_W'($urandom_range(25000, 35000)));
        in_gap_max = 19;
    endtask

    // Random register sets; most beats come from a simple plant that follows
    // the drive, the rest sit near the setpoint, jump around or sit on the rails.
    task automatic test_random_loop();
        int pv;
        int k;
        for (int ph = 0; ph < 7; ph++)
        begin
            write_all(rand_reg16(), rand_gain(), rand_gain(), rand_gain(),
                      rand_reg16(), rand_reg16(), rand_reg16());
            in_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 19;
            out_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 19;
            pv = $urandom_range(0, 65535);
            repeat (200)
            begin
                k = $urandom_range(0, 99);
                if (k < 55)
                    pv = pv + (int'(last_drive) - pv) / 8 + int'($urandom_range(0, 64)) - 32;
                else if (k < 70)
                    pv = int'(cfg_sp) + int'($urandom_range(0, 8)) - 4;
                else if (k < 85)
                    pv = $urandom_range(0, 65535);
                else if (k < 92)
                    pv = 0;
                else
                    pv = 65535;
                if (pv < 0)
                    pv = 0;
                if (pv > 65535)
                    pv = 65535;
                send_meas(MEAS_W'(pv));
            end
        end
        in_gap_max = 19;
        out_gap_max = 19;
    endtask

    // Drive the tracker up in full steps with a zero threshold for a stretch,
    // far past the upper clamp, then step it back down with the integral
    // gain cleared.
    task automatic test_tracker_wrap();
        logic signed [TRACK_W-1:0] was;
        int n;
        write_all(40'hFFFF, GAIN_MAX, GAIN_MAX, '0, 40'hFFFF, '0, 40'hFFFF);
        in_gap_max = 0;
        out_gap_max = 0;
        n = 0;
        do
        begin
            was = track_val;
            send_meas(16'd0);
            n++;
        end
        while (track_val >= was && n < 150);
        write_reg(REG_KI, '0);
        write_reg(REG_SETPOINT, '0);
        n = 0;
        do
        begin
            was = track_val;
            send_meas(16'hFFFF);
            n++;
        end
        while (track_val <= was && n < 4);
    endtask

    // ------------------------------------------------------------------
    // Sequence: reset once, run each test, drain, report.
    // ------------------------------------------------------------------
    initial
    begin
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        test_reset_values();
        test_slew_edges();
        test_truncation();
        test_register_extremes();
        test_backpressure();
        test_random_loop();
        test_tracker_wrap();
        settle();
        if (fail_cnt == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### files.f
rtl/pidsl_pkg.sv
rtl/pidsl_front.sv
rtl/pidsl_mult.sv
rtl/pidsl_out.sv
rtl/pid_controller_slew_limited.sv
bench/testbench.sv
